// ===== rtl/compass_heading_from_magnetometer_assert.svh =====
// ----------------------------------------------------------------------------
// Compass heading assertion macros
// Shared concurrent assertion forms for the compass heading RTL.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_FROM_MAGNETOMETER_ASSERT_SVH
`define COMPASS_HEADING_FROM_MAGNETOMETER_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define CMH_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks a property in the cycle that follows a cycle spent in reset.
`define CMH_ASSERT_AFTER_RESET(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) !rstn |=> (prop)) else $error(msg);

`endif

// ===== rtl/cmh_pkg.sv =====
// ----------------------------------------------------------------------------
// Compass heading package
// Widths, constants, angle table and record types shared by the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmh_pkg;

    localparam int RAW_W     = 13;
    localparam int OFF_W     = 12;
    localparam int ROT_W     = 14;
    localparam int HEAD_W    = 12;
    localparam int FRAC_W    = 16;
    localparam int VEC_W     = 32;
    localparam int ANG_W     = 30;
    localparam int T_W       = ANG_W - FRAC_W;
    localparam int TABLE_LEN = 24;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;

    localparam logic [OFF_W-1:0] X_OFFSET_RESET = 12'd25;
    localparam logic [OFF_W-1:0] Y_OFFSET_RESET = 12'd104;

    localparam logic [T_W-1:0]   FULL_TURN_TENTHS = 14'd3600;
    localparam logic [ANG_W-1:0] HALF_TURN_Q      = 30'd1800 << FRAC_W;
    localparam logic [ANG_W-1:0] FULL_TURN_Q      = 30'd3600 << FRAC_W;
    localparam logic [ANG_W-1:0] ROUND_HALF_Q     = 30'd1 << (FRAC_W - 1);

    // Entry i is round(atan(2^-i) * 1800 / pi * 2^16).
    localparam logic [ANG_W-1:0] ANGLE_STEP [TABLE_LEN] = '{
        30'd29491200, 30'd17409672, 30'd9198793, 30'd4669451,
        30'd2343786,  30'd1173036,  30'd586661,  30'd293348,
        30'd146676,   30'd73339,    30'd36669,   30'd18335,
        30'd9167,     30'd4584,     30'd2292,    30'd1146,
        30'd573,      30'd286,      30'd143,     30'd72,
        30'd36,       30'd18,       30'd9,       30'd4
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
        logic signed [ROT_W-1:0] rot_x;
        logic signed [ROT_W-1:0] rot_y;
    } cmh_vec_t;

    typedef struct packed {
        logic        [HEAD_W-1:0] heading;
        logic signed [ROT_W-1:0]  rot_y;
        logic signed [ROT_W-1:0]  rot_x;
    } cmh_out_t;

endpackage

`default_nettype wire

// ===== rtl/cmh_prep.sv =====
// ----------------------------------------------------------------------------
// Compass heading front stage
// Holds the offset registers, corrects and rotates the sample and sets up
// the CORDIC vector with its half-turn pre-rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmh_prep (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cmh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cmh_pkg::OFF_W-1:0]     cfg_wdata,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [cmh_pkg::S_TDATA_W-1:0] in_data,
    output logic                               out_valid,
    output cmh_pkg::cmh_vec_t                  out_vec
);
    import cmh_pkg::*;

    logic [OFF_W-1:0] x_offset_reg, x_offset_next;
    logic [OFF_W-1:0] y_offset_reg, y_offset_next;
    logic             valid_reg;
    cmh_vec_t         vec_reg, vec_next;

    logic [RAW_W-1:0]        raw_x, raw_y;
    logic signed [ROT_W-1:0] cx, cy, rx, ry, px, py;
    logic                    flip;

    always_comb begin
        x_offset_next = x_offset_reg;
        y_offset_next = y_offset_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_X_OFFSET: x_offset_next = cfg_wdata;
                REG_Y_OFFSET: y_offset_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign raw_x = in_data[RAW_W-1:0];
    assign raw_y = in_data[2*RAW_W-1:RAW_W];

    assign cx = {{(ROT_W-RAW_W){raw_x[RAW_W-1]}}, raw_x}
              + {{(ROT_W-OFF_W){x_offset_reg[OFF_W-1]}}, x_offset_reg};
    assign cy = {{(ROT_W-RAW_W){raw_y[RAW_W-1]}}, raw_y}
              + {{(ROT_W-OFF_W){y_offset_reg[OFF_W-1]}}, y_offset_reg};
    assign rx = -cy;
    assign ry = cx;

    assign flip = rx[ROT_W-1];
    assign px   = flip ? -rx : rx;
    assign py   = flip ? -ry : ry;

    always_comb begin
        vec_next.x     = {{(VEC_W-ROT_W-FRAC_W){px[ROT_W-1]}}, px, {FRAC_W{1'b0}}};
        vec_next.y     = {{(VEC_W-ROT_W-FRAC_W){py[ROT_W-1]}}, py, {FRAC_W{1'b0}}};
        vec_next.z     = flip ? HALF_TURN_Q : '0;
        vec_next.zero  = (rx == '0) && (ry == '0);
        vec_next.rot_x = rx;
        vec_next.rot_y = ry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_offset_reg <= X_OFFSET_RESET;
            y_offset_reg <= Y_OFFSET_RESET;
            valid_reg    <= 1'b0;
        end else begin
            x_offset_reg <= x_offset_next;
            y_offset_reg <= y_offset_next;
            if (en) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== rtl/cmh_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// Compass heading CORDIC stage
// One registered vectoring micro-rotation by atan(2^-STAGE).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmh_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  cmh_pkg::cmh_vec_t       in_vec,
    output logic                    out_valid,
    output cmh_pkg::cmh_vec_t       out_vec
);
    import cmh_pkg::*;

    logic                    valid_reg;
    cmh_vec_t                vec_reg, vec_next;
    logic signed [VEC_W-1:0] dx, dy;

    assign dx = $signed(in_vec.y) >>> STAGE;
    assign dy = $signed(in_vec.x) >>> STAGE;

    always_comb begin
        vec_next = in_vec;
        if (!in_vec.y[VEC_W-1]) begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + ANGLE_STEP[STAGE];
        end else begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - ANGLE_STEP[STAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== rtl/cmh_finish.sv =====
// ----------------------------------------------------------------------------
// Compass heading output stage
// Wraps and rounds the angle to tenths of a degree and holds results in an
// output register backed by a one-entry skid buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "compass_heading_from_magnetometer_assert.svh"

module cmh_finish (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  cmh_pkg::cmh_vec_t                  in_vec,
    output logic                               adv,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [cmh_pkg::M_TDATA_W-1:0]      m_tdata
);
    import cmh_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    cmh_out_t         out_reg, skid_reg, res;
    logic             load_out, load_skid, pop_skid;

    logic [ANG_W-1:0] z_wrap, z_round;
    logic [T_W-1:0]   t_raw, t_wrap;

    assign z_wrap  = in_vec.z[ANG_W-1] ? in_vec.z + FULL_TURN_Q : in_vec.z;
    assign z_round = z_wrap + ROUND_HALF_Q;
    assign t_raw   = z_round[ANG_W-1:FRAC_W];
    assign t_wrap  = (t_raw >= FULL_TURN_TENTHS) ? t_raw - FULL_TURN_TENTHS : t_raw;

    always_comb begin
        res.rot_x   = in_vec.rot_x;
        res.rot_y   = in_vec.rot_y;
        res.heading = in_vec.zero ? '0 : t_wrap[HEAD_W-1:0];
    end

    assign adv = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        pop_skid        = 1'b0;
        if (skid_valid_reg) begin
            if (m_tready) begin
                pop_skid        = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || m_tready) begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_skid) begin
            out_reg <= skid_reg;
        end else if (load_out) begin
            out_reg <= res;
        end
        if (load_skid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `CMH_ASSERT(a_skid_behind_out, aclk, aresetn,
        skid_valid_reg |-> out_valid_reg, "skid holds a result while output is empty")
    `CMH_ASSERT(a_skid_fills_on_stall, aclk, aresetn,
        (out_valid_reg && !m_tready && in_valid && adv) |=> skid_valid_reg,
        "stalled result was not captured in the skid buffer")
    `CMH_ASSERT(a_heading_range, aclk, aresetn,
        out_valid_reg |-> (out_reg.heading < HEAD_W'(FULL_TURN_TENTHS)),
        "heading outside one full turn")
    `CMH_ASSERT_AFTER_RESET(a_empty_after_reset, aclk, aresetn,
        !out_valid_reg && !skid_valid_reg, "output stage not empty after reset")

endmodule

`default_nettype wire

// ===== rtl/compass_heading_from_magnetometer.sv =====
// ----------------------------------------------------------------------------
// Compass heading from magnetometer
// Offset correction, quarter-turn rotation and CORDIC atan2 heading pipeline.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while s_tready is high and returns
// one result per request, in order. Each request passes through the front
// stage register, one registered micro-rotation per CORDIC stage (at most
// TABLE_LEN stages) and the output register. A one-entry skid buffer lets
// the block accept a request while a result waits; s_tready drops only while
// that buffer is occupied. The user must write the offset registers through
// the cfg port only while no request is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_from_magnetometer #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cmh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cmh_pkg::OFF_W-1:0]     cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata fields from bit 0: raw_x[12:0], raw_y[25:13], zero pad[31:26]
    input  wire logic [cmh_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata fields from bit 0: rotated_x[13:0], rotated_y[27:14],
    // heading_tenths[39:28]
    output logic [cmh_pkg::M_TDATA_W-1:0]      m_tdata
);
    import cmh_pkg::*;

    localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    logic           adv;
    logic [N:0]     valid_chain;
    cmh_vec_t       vec_chain [N+1];

    cmh_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (valid_chain[0]),
        .out_vec   (vec_chain[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_stage
        cmh_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (valid_chain[i]),
            .in_vec    (vec_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_vec   (vec_chain[i+1])
        );
    end

    cmh_finish u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_chain[N]),
        .in_vec   (vec_chain[N]),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = adv;

endmodule

`default_nettype wire
